FILE: src/slid_pkg.sv
// Shared types and constants for the sorted list block.
`timescale 1ns / 1ps
package slid_pkg;

	// Fixed field widths of the request and result.
	localparam int DATA_W   = 8;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 5;

	// Status codes returned with every result.
	typedef enum logic [STATUS_W-1:0] {
		ST_INSERTED = 3'd0,
		ST_DELETED  = 3'd1,
		ST_NOTFOUND = 3'd2,
		ST_FULL     = 3'd3,
		ST_EMPTY    = 3'd4
	} status_t;

	// Operation selected by the mode field.
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DELETE = 1'b1;

	// Result handed from the sequencer to the output register.
	typedef struct packed {
		status_t              status;
		logic [COUNT_W-1:0]   count;
	} result_t;

endpackage

FILE: src/slid_mem.sv
// Entry storage: one write port and one registered read port.
`timescale 1ns / 1ps
module slid_mem #(
	parameter int DEPTH = 16,
	parameter int AW    = 4
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [slid_pkg::DATA_W-1:0] wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr,
	output logic [slid_pkg::DATA_W-1:0] rdata
);
	import slid_pkg::*;

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/slid_ctrl.sv
// Sequencer that walks the entry memory to insert or delete one value.
`timescale 1ns / 1ps
module slid_ctrl #(
	parameter int CAPACITY = 16,
	parameter int AW       = 4,
	parameter int CNT_W    = 5
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        mode,
	input  logic signed [slid_pkg::DATA_W-1:0] value,
	output logic                        res_valid,
	input  logic                        res_ready,
	output slid_pkg::result_t           res,
	output logic                        mem_we,
	output logic [AW-1:0]               mem_waddr,
	output logic [slid_pkg::DATA_W-1:0] mem_wdata,
	output logic                        mem_re,
	output logic [AW-1:0]               mem_raddr,
	input  logic [slid_pkg::DATA_W-1:0] mem_rdata
);
	import slid_pkg::*;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_INS  = 5'b00010,
		S_INS0 = 5'b00100,
		S_DEL  = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                    state_q;
	logic [CNT_W-1:0]          cnt_q;
	logic signed [DATA_W-1:0]  value_q;
	status_t                   status_q;
	logic [AW-1:0]             rd_ptr_q;
	logic                      rd_more_q;
	logic                      found_q;
	logic                      pend_s1;
	logic [AW-1:0]             idx_s1;

	logic [CNT_W-1:0]          cnt_m1;
	logic [CNT_W+COUNT_W-1:0]  cnt_ext;
	logic signed [DATA_W-1:0]  rd_val;
	logic                      rd_ge;
	logic                      rd_eq;
	logic                      rd_last;
	logic                      accept;

	// Derived comparisons on the returning read data.
	assign cnt_m1  = cnt_q - 1'b1;
	assign rd_val  = $signed(mem_rdata);
	assign rd_ge   = (rd_val >= value_q);
	assign rd_eq   = (rd_val == value_q);
	assign rd_last = (CNT_W'(idx_s1) == cnt_m1);
	assign accept  = in_valid && in_ready;

	// Handshake and result.
	assign in_ready   = (state_q == S_IDLE);
	assign res_valid  = (state_q == S_DONE);
	assign cnt_ext    = (CNT_W+COUNT_W)'(cnt_q);
	assign res.status = status_q;
	assign res.count  = cnt_ext[COUNT_W-1:0];

	// Read side: one entry per cycle while a walk is in progress.
	assign mem_re    = ((state_q == S_INS) || (state_q == S_DEL)) && rd_more_q;
	assign mem_raddr = rd_ptr_q;

	// Write side: shift entries up and write the new value for an insert, shift down for a delete.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = '0;
		mem_wdata = value_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && (mode == MODE_INSERT) && (cnt_q == '0)) begin
					mem_we    = 1'b1;
					mem_wdata = value;
				end
			end
			S_INS: begin
				if (pend_s1) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1 + 1'b1;
					mem_wdata = rd_ge ? mem_rdata : value_q;
				end
			end
			S_INS0: begin
				mem_we = 1'b1;
			end
			S_DEL: begin
				if (pend_s1 && found_q) begin
					mem_we    = 1'b1;
					mem_waddr = idx_s1 - 1'b1;
					mem_wdata = mem_rdata;
				end
			end
			S_DONE: begin
				mem_we = 1'b0;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// Request payload register.
	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= value;
		end
	end

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			status_q  <= ST_INSERTED;
			rd_ptr_q  <= '0;
			rd_more_q <= 1'b0;
			found_q   <= 1'b0;
			pend_s1   <= 1'b0;
			idx_s1    <= '0;
		end else begin
			pend_s1 <= mem_re;
			idx_s1  <= rd_ptr_q;
			if (mem_re) begin
				if (state_q == S_INS) begin
					if (rd_ptr_q == '0) begin
						rd_more_q <= 1'b0;
					end else begin
						rd_ptr_q <= rd_ptr_q - 1'b1;
					end
				end else begin
					if (CNT_W'(rd_ptr_q) == cnt_m1) begin
						rd_more_q <= 1'b0;
					end else begin
						rd_ptr_q <= rd_ptr_q + 1'b1;
					end
				end
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						found_q <= 1'b0;
						if (mode == MODE_INSERT) begin
							if (cnt_q == CNT_W'(CAPACITY)) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else if (cnt_q == '0) begin
								cnt_q    <= CNT_W'(1);
								status_q <= ST_INSERTED;
								state_q  <= S_DONE;
							end else begin
								rd_ptr_q  <= AW'(cnt_m1);
								rd_more_q <= 1'b1;
								state_q   <= S_INS;
							end
						end else begin
							if (cnt_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								rd_ptr_q  <= '0;
								rd_more_q <= 1'b1;
								state_q   <= S_DEL;
							end
						end
					end
				end
				S_INS: begin
					if (pend_s1) begin
						if (rd_ge) begin
							if (idx_s1 == '0) begin
								state_q <= S_INS0;
							end
						end else begin
							cnt_q    <= cnt_q + 1'b1;
							status_q <= ST_INSERTED;
							state_q  <= S_DONE;
						end
					end
				end
				S_INS0: begin
					cnt_q    <= cnt_q + 1'b1;
					status_q <= ST_INSERTED;
					state_q  <= S_DONE;
				end
				S_DEL: begin
					if (pend_s1) begin
						if (rd_eq) begin
							found_q <= 1'b1;
						end
						if (rd_last) begin
							state_q <= S_DONE;
							if (found_q || rd_eq) begin
								cnt_q    <= cnt_m1;
								status_q <= ST_DELETED;
							end else begin
								status_q <= ST_NOTFOUND;
							end
						end
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The walk never writes the entry it reads in the same cycle.
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re && (mem_waddr == mem_raddr)))
		else $error("read and write hit the same entry");

	// The entry count stays within the capacity.
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	// Returning read data always follows an issued read.
	a_pend_read: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(mem_re))
		else $error("read data tracked without a read");

	// A handed-off result returns the sequencer to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_ready) |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle");

endmodule

FILE: src/sorted_list_insert_delete.sv
// Top level of the bounded sorted list with insert and delete requests.
//
// Requests arrive on in_valid/in_ready with fields mode (0 insert, 1 delete)
// and value (signed 8 bits). Each request yields exactly one result on
// out_valid/out_ready with status and entry_count (entries held afterward).
// The entries sit in a memory with one registered read port; a request walks
// the held entries one per cycle, shifting them up for an insert (from the top
// down) or down for a delete (from the match onward).
// A full insert, an insert on an empty list or a delete on an empty list goes
// straight to its result without walking the memory; every other request
// walks the memory read loop, one entry per cycle, before its result is loaded.
// Only one request is in flight at a time; in_ready is high when the
// sequencer is idle, from the cycle after its result is loaded.
// The result sits in an output register, so the sequencer can finish its next
// request while the receiver stalls; it then waits until the register frees.
// Reset clears the entry count and the handshake state; the memory itself is
// not cleared, since only entries below the count are ever read.
`timescale 1ns / 1ps
module sorted_list_insert_delete #(
	parameter int CAPACITY = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               mode,
	input  logic signed [slid_pkg::DATA_W-1:0] value,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [slid_pkg::STATUS_W-1:0]      status,
	output logic [slid_pkg::COUNT_W-1:0]       entry_count
);
	import slid_pkg::*;

	localparam int AW    = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [DATA_W-1:0] mem_wdata;
	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [DATA_W-1:0] mem_rdata;
	logic              res_valid;
	logic              res_ready;
	result_t           res;
	logic              out_valid_q;
	result_t           out_q;

	slid_mem #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	slid_ctrl #(
		.CAPACITY (CAPACITY),
		.AW       (AW),
		.CNT_W    (CNT_W)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.mode      (mode),
		.value     (value),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	// Output register: free when empty or when its result is being taken.
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign status      = out_q.status;
	assign entry_count = out_q.count;

endmodule
